/* src/lzwd_pkg.sv */
// Package: shared constants, types and codes of the LZ window decompressor.
`timescale 1ns / 1ps
package lzwd_pkg;

	localparam int WIN_DEPTH = 2048;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int OFF_W     = 11;
	localparam int LEN_W     = 5;
	localparam int CNT_W     = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_BITS,
		PH_LOW,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_MATCH,
		CMD_END
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_COPY
	} bk_state_t;

	// One unit of work for the back end. For a literal, data[7:0] is the byte;
	// for a match, data is the big-endian match word.
	typedef struct packed {
		cmd_kind_t   kind;
		logic        rst;
		logic [15:0] data;
	} cmd_t;

endpackage

/* src/lzwd_in_if.sv */
// Interface: input channel carrying compressed bytes.
`timescale 1ns / 1ps
interface lzwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       restart;

	modport source (output valid, output in_byte, output restart, input ready);
	modport sink (input valid, input in_byte, input restart, output ready);
endinterface

/* src/lzwd_out_if.sv */
// Interface: output channel carrying decompressed bytes and stream status.
`timescale 1ns / 1ps
interface lzwd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        stream_done;
	logic [31:0] total_length;

	modport source (output valid, output out_byte, output last_of_run,
		output stream_done, output total_length, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input stream_done, input total_length, output ready);
endinterface

/* src/lz_window_decompressor_core.sv */
// Top level: LZ window decompressor with a parsing front end, a command queue
// and a history-copy back end.
//
//  Channel  | Direction | Payload                                       | Handshake
//  ---------+-----------+-----------------------------------------------+------------
//  in_ch    | sink      | in_byte[7:0], restart                         | valid/ready
//  out_ch   | source    | out_byte[7:0], last_of_run, stream_done,      | valid/ready
//           |           | total_length[31:0]                            |
//
// One input item per cycle enters while the command queue has room. A literal
// is emitted straight from the idle state; a match first issues a history read
// and then copies its bytes one by one in the copy state.
// The asynchronous active-low reset clears parser, queue and counters, not history.
// An output stall freezes the copy in place and lets the queue fill; once it is
// full the input side stalls too.
`timescale 1ns / 1ps
module lz_window_decompressor_core import lzwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lzwd_in_if.sink   in_ch,
	lzwd_out_if.source out_ch
);

	// Commands travel from the parser to the executor through a small queue so
	// that flag bytes can be parsed while a long match is still being copied.
	logic q_push, q_pop, q_empty, q_full;
	cmd_t q_in, q_head;

	lzwd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (q_in)
	);

	lzwd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// The executor owns the history window, the write position and the
	// saturating byte count; a restart reaches it as a flag on the next command.
	lzwd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

endmodule

/* src/lzwd_front.sv */
// Front end: parses flag bits and match words into commands for the back end.
`timescale 1ns / 1ps
module lzwd_front import lzwd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lzwd_in_if.sink      in_ch,
	input  logic         q_full,
	output logic         push,
	output cmd_t         push_cmd
);

	phase_t     phase_q, phase_d;
	logic [7:0] flag_q, flag_d;
	logic [7:0] mh_q, mh_d;
	logic       pend_q, pend_d;

	logic       acc;
	phase_t     ph_eff;
	logic [7:0] flag_eff;
	logic [7:0] flag_shr;
	logic       pend_eff;

	assign in_ch.ready = !q_full;
	assign acc      = in_ch.valid && in_ch.ready;
	assign ph_eff   = in_ch.restart ? PH_FLAG : phase_q;
	assign flag_eff = in_ch.restart ? 8'd0 : flag_q;
	assign flag_shr = flag_eff >> 1;
	assign pend_eff = pend_q || in_ch.restart;

	// Next state.
	always_comb begin
		phase_d = phase_q;
		flag_d  = flag_q;
		mh_d    = mh_q;
		if (acc) begin
			phase_d = ph_eff;
			flag_d  = flag_eff;
			case (ph_eff)
				PH_FLAG: begin
					if (in_ch.in_byte == 8'd0) begin
						phase_d = PH_DONE;
					end else if (in_ch.in_byte >= 8'd2) begin
						flag_d  = in_ch.in_byte;
						phase_d = PH_BITS;
					end
				end
				PH_BITS: begin
					flag_d = flag_shr;
					if (flag_eff[0]) begin
						phase_d = (flag_shr > 8'd1) ? PH_BITS : PH_FLAG;
					end else begin
						mh_d    = in_ch.in_byte;
						phase_d = PH_LOW;
					end
				end
				PH_LOW: begin
					phase_d = (flag_eff > 8'd1) ? PH_BITS : PH_FLAG;
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	// Outputs: command pushed toward the back end.
	always_comb begin
		push          = 1'b0;
		push_cmd.kind = CMD_LIT;
		push_cmd.rst  = pend_eff;
		push_cmd.data = {8'd0, in_ch.in_byte};
		if (acc) begin
			case (ph_eff)
				PH_FLAG: begin
					if (in_ch.in_byte == 8'd0) begin
						push          = 1'b1;
						push_cmd.kind = CMD_END;
					end
				end
				PH_BITS: begin
					if (flag_eff[0]) begin
						push          = 1'b1;
						push_cmd.kind = CMD_LIT;
					end
				end
				PH_LOW: begin
					push          = 1'b1;
					push_cmd.kind = CMD_MATCH;
					push_cmd.data = {mh_q, in_ch.in_byte};
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// A restart on a byte that yields no command rides on the next command.
	always_comb begin
		pend_d = pend_q;
		if (acc) begin
			pend_d = push ? 1'b0 : pend_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_q  <= 8'd0;
			mh_q    <= 8'd0;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			flag_q  <= flag_d;
			mh_q    <= mh_d;
			pend_q  <= pend_d;
		end
	end

	a_bits_have_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BITS) |-> (flag_q > 8'd1))
		else $error("flag bits exhausted while expecting a data byte");

endmodule

/* src/lzwd_cmd_fifo.sv */
// Command queue between the front end and the back end.
`timescale 1ns / 1ps
module lzwd_cmd_fifo import lzwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command popped from an empty queue");

endmodule

/* src/lzwd_back.sv */
// Back end: executes commands against the history window and drives the output.
`timescale 1ns / 1ps
module lzwd_back import lzwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      empty,
	output logic      pop,
	lzwd_out_if.source out_ch
);

	localparam logic [WIN_AW:0]   WIN_X    = (WIN_AW+1)'(WIN_DEPTH);
	localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WIN_DEPTH - 1);

	function automatic logic [WIN_AW-1:0] win_inc(input logic [WIN_AW-1:0] a);
		return (a == WIN_LAST) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	logic [7:0] hist_q [WIN_DEPTH];

	bk_state_t         st_q, st_d;
	logic [WIN_AW-1:0] wp_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  remain_q;
	logic              rv_q;
	logic [7:0]        mem_rd_q, bdata_q;
	logic              byp_q;
	logic              ov_q;
	logic [7:0]        ob_q;
	logic              olast_q, odone_q;
	logic [CNT_W-1:0]  otot_q;

	logic              emit_ok;
	logic [WIN_AW-1:0] wp_base;
	logic [CNT_W-1:0]  cnt_base;
	logic [OFF_W:0]    off;
	logic [WIN_AW:0]   rd_sum, rd_start;
	logic [7:0]        rbyte;
	logic              emit, e_last, e_done;
	logic [7:0]        e_byte;
	logic [CNT_W-1:0]  e_total;
	logic              we, issue, consume, rebase;
	logic [WIN_AW-1:0] raddr;
	logic [7:0]        wdata;

	assign emit_ok = !ov_q || out_ch.ready;
	assign rbyte   = byp_q ? bdata_q : mem_rd_q;

	// Start of a new command: a restart clears the write position and count.
	assign wp_base  = (st_q == BK_IDLE && head.rst) ? '0 : wp_q;
	assign cnt_base = (st_q == BK_IDLE && head.rst) ? '0 : cnt_q;

	assign off      = (head.data[OFF_W-1:0] == '0) ? (OFF_W+1)'(1 << OFF_W)
	                                               : {1'b0, head.data[OFF_W-1:0]};
	assign rd_sum   = {1'b0, wp_base} + WIN_X - (WIN_AW+1)'(off);
	assign rd_start = (rd_sum >= WIN_X) ? rd_sum - WIN_X : rd_sum;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (!empty && head.kind == CMD_MATCH) begin
					st_d = BK_COPY;
				end
			end
			BK_COPY: begin
				if (rv_q && emit_ok && remain_q == '0) begin
					st_d = BK_IDLE;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	// Datapath controls.
	always_comb begin
		pop     = 1'b0;
		emit    = 1'b0;
		e_byte  = 8'd0;
		e_last  = 1'b1;
		e_done  = 1'b0;
		e_total = sat_inc(cnt_base);
		we      = 1'b0;
		wdata   = 8'd0;
		issue   = 1'b0;
		consume = 1'b0;
		rebase  = 1'b0;
		raddr   = rd_q;
		case (st_q)
			BK_IDLE: begin
				if (!empty) begin
					case (head.kind)
						CMD_LIT: begin
							if (emit_ok) begin
								pop    = 1'b1;
								rebase = 1'b1;
								emit   = 1'b1;
								e_byte = head.data[7:0];
								we     = 1'b1;
								wdata  = head.data[7:0];
							end
						end
						CMD_END: begin
							if (emit_ok) begin
								pop     = 1'b1;
								rebase  = 1'b1;
								emit    = 1'b1;
								e_done  = 1'b1;
								e_total = cnt_base;
							end
						end
						CMD_MATCH: begin
							pop    = 1'b1;
							rebase = 1'b1;
							issue  = 1'b1;
							raddr  = rd_start[WIN_AW-1:0];
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_COPY: begin
				consume = rv_q && emit_ok;
				if (consume) begin
					emit   = 1'b1;
					e_byte = rbyte;
					e_last = (remain_q == '0);
					we     = 1'b1;
					wdata  = rbyte;
				end
				issue = (remain_q != '0) && (!rv_q || consume);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// History window: one write port, one registered read port. A read of the
	// slot being written in the same cycle takes the new byte via the bypass.
	always_ff @(posedge clk) begin
		if (we) begin
			hist_q[wp_base] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_rd_q <= hist_q[raddr];
			byp_q    <= we && (raddr == wp_base);
			bdata_q  <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q    <= e_byte;
			olast_q <= e_last;
			odone_q <= e_done;
			otot_q  <= e_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			wp_q     <= '0;
			cnt_q    <= '0;
			rd_q     <= '0;
			remain_q <= '0;
			rv_q     <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (we) begin
				wp_q  <= win_inc(wp_base);
				cnt_q <= sat_inc(cnt_base);
			end else if (rebase) begin
				wp_q  <= wp_base;
				cnt_q <= cnt_base;
			end
			if (issue) begin
				rd_q     <= win_inc(raddr);
				rv_q     <= 1'b1;
				remain_q <= (st_q == BK_IDLE) ? head.data[15:11] - 1'b1
				                              : remain_q - 1'b1;
			end else if (consume) begin
				rv_q <= 1'b0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.out_byte     = ob_q;
	assign out_ch.last_of_run  = olast_q;
	assign out_ch.stream_done  = odone_q;
	assign out_ch.total_length = otot_q;

	a_copy_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_COPY) |-> rv_q)
		else $error("copy in progress without a pending history read");

	a_match_starts_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_IDLE && pop && head.kind == CMD_MATCH) |=> (st_q == BK_COPY && rv_q))
		else $error("match command did not start a copy");

	a_no_emit_over_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |-> !emit)
		else $error("new result overwrote a stalled output");

endmodule

/* verif/lz_window_decompressor_core_tb.sv */
// Testbench: checks the LZ window decompressor against a cycle-free decoder of its own.
`timescale 1ns / 1ps
module lz_window_decompressor_core_tb import lzwd_pkg::*;;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 40;

	// One decompressed output item as the block should present it.
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic             done;
		logic [CNT_W-1:0] total;
	} out_item_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_COMB
	} rx_style_t;

	logic clk;
	logic arst_n;

	lzwd_in_if  in_ch ();
	lzwd_out_if out_ch ();

	lz_window_decompressor_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Decoder state, kept in step with every item the block accepts.
	phase_t           dec_phase = PH_FLAG;
	logic [7:0]       dec_flags = '0;
	logic [7:0]       dec_high = '0;
	logic [7:0]       window [WIN_DEPTH];
	logic [WIN_AW-1:0] wr_pos = '0;
	logic [CNT_W-1:0] produced = '0;
	bit               window_full = 1'b0;

	out_item_t decoded_q[$];

	// Low byte of the match word whose high byte went out last.
	logic [7:0] copy_low = '0;

	int        fail_count = 0;
	int        idle_cycles = 0;
	int        tx_burst_left = 4;
	bit        tx_steady = 1'b0;
	bit        tx_valid_high = 1'b0;
	int        rx_hold = 0;
	int        rx_style_left = 0;
	rx_style_t rx_style = RX_OPEN;
	logic [7:0] rx_comb = 8'b1101_0110;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Slots behind the write pointer that hold written data. History is only
	// ever filled from slot 0 upward, so until the first wrap it is a prefix.
	function automatic int reach_back(input int w);
		return window_full ? WIN_DEPTH : w;
	endfunction

	task automatic put_byte(input logic [7:0] v, input logic is_last);
		window[wr_pos] = v;
		if (wr_pos == WIN_AW'(WIN_DEPTH - 1))
			window_full = 1'b1;
		wr_pos++;
		if (produced != CNT_MAX)
			produced++;
		decoded_q.push_back(out_item_t'{data: v, last: is_last, done: 1'b0,
			total: produced});
	endtask

	// Advances the decoder by one compressed byte and queues what it yields.
	task automatic decode_step(input logic [7:0] b, input logic r);
		logic [15:0]       word;
		int                off;
		int                len;
		logic [WIN_AW-1:0] rd;
		if (r) begin
			dec_phase = PH_FLAG;
			dec_flags = '0;
			dec_high = '0;
			wr_pos = '0;
			produced = '0;
		end
		case (dec_phase)
			PH_FLAG: begin
				if (b == 8'h00) begin
					decoded_q.push_back(out_item_t'{data: 8'h00, last: 1'b1,
						done: 1'b1, total: produced});
					dec_phase = PH_DONE;
				end else if (b >= 8'h02) begin
					dec_flags = b;
					dec_phase = PH_BITS;
				end
			end
			PH_BITS: begin
				if (dec_flags[0]) begin
					dec_flags = dec_flags >> 1;
					put_byte(b, 1'b1);
					dec_phase = (dec_flags > 8'h01) ? PH_BITS : PH_FLAG;
				end else begin
					dec_flags = dec_flags >> 1;
					dec_high = b;
					dec_phase = PH_LOW;
				end
			end
			PH_LOW: begin
				word = {dec_high, b};
				off = (word[OFF_W-1:0] == '0) ? WIN_DEPTH : int'(word[OFF_W-1:0]);
				len = (word[15:OFF_W] == '0) ? 32 : int'(word[15:OFF_W]);
				rd = wr_pos - off[WIN_AW-1:0];
				// Byte by byte, so a copy may read what it wrote a moment ago.
				for (int i = 0; i < len; i++) begin
					put_byte(window[rd], i == len - 1);
					rd++;
				end
				dec_phase = (dec_flags > 8'h01) ? PH_BITS : PH_FLAG;
			end
			default: ;
		endcase
	endtask

	// Picks the next compressed byte so that the stream stays well formed:
	// no match ever reaches a history slot that was never written. With
	// noisy set, restarts, early ends and bare flag fetches are mixed in.
	task automatic next_stream_byte(input int match_pct, input bit long_copy,
			input bit noisy, output logic [7:0] b, output logic r, output bit counts);
		phase_t      ph;
		int          s;
		int          span;
		int          off;
		int          len;
		logic [15:0] word;
		r = 1'b0;
		counts = 1'b1;
		ph = dec_phase;
		if (ph == PH_DONE) begin
			// After the end mark, bytes are dropped until a restart.
			if ($urandom_range(0, 2) == 0) begin
				b = 8'($urandom_range(0, 255));
				counts = 1'b0;
				return;
			end
			r = 1'b1;
		end else if (noisy && $urandom_range(0, 99) < 3) begin
			r = 1'b1;
		end
		if (r)
			ph = PH_FLAG;
		case (ph)
			PH_FLAG: begin
				s = $urandom_range(0, 99);
				if (noisy && s < 6) begin
					b = 8'h00;
				end else if (noisy && s < 10) begin
					b = 8'h01;
				end else begin
					s = $urandom_range(1, 7);
					b = 8'(1 << s);
					for (int k = 0; k < s; k++)
						if ($urandom_range(0, 99) >= match_pct)
							b[k] = 1'b1;
					// Nothing to copy from yet: the first code must be a literal.
					if (reach_back(r ? 0 : int'(wr_pos)) == 0)
						b[0] = 1'b1;
				end
			end
			PH_BITS: begin
				if (dec_flags[0]) begin
					b = 8'($urandom_range(0, 255));
				end else begin
					span = reach_back(int'(wr_pos));
					if ($urandom_range(0, 1))
						off = $urandom_range(1, (span < 8) ? span : 8);
					else
						off = $urandom_range(1, span);
					if (long_copy && $urandom_range(0, 99) < 80)
						len = 32;
					else
						len = $urandom_range(1, 32);
					// 32 and 2048 both encode as zero in their fields.
					word = {len[LEN_W-1:0], off[OFF_W-1:0]};
					b = word[15:8];
					copy_low = word[7:0];
				end
			end
			default: b = copy_low;
		endcase
	endtask

	// Offers one item and holds it until the block takes it. Unless tx_steady is
	// set, the sender runs in bursts; at the end of a burst valid drops for a random gap.
	task automatic send_item(input logic [7:0] b, input logic r);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.restart <= r;
		tx_valid_high = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		decode_step(b, r);
		if (!tx_steady) begin
			tx_burst_left--;
			if (tx_burst_left <= 0) begin
				gap = $urandom_range(1, 6);
				tx_burst_left = $urandom_range(1, 16);
				in_ch.valid <= 1'b0;
				tx_valid_high = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hand-picked stream: flag fetch, literal extremes, an overlapping copy of
	// length 32, a copy spanning everything so far, the end mark, a dropped
	// byte after the end, a restart, and a restart that lands mid-match.
	task automatic test_directed();
		send_item(8'h01, 1'b0);
		send_item(8'h0B, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'hFE, 1'b0);
		send_item(8'hF8, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'hFE, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h37, 1'b0);
		send_item(8'h03, 1'b1);
		send_item(8'h5A, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Fills the whole window with long copies, ends the stream, then restarts and copies 32
	// bytes from offset 2048, which reads the previous stream's output, and ends again.
	task automatic test_window_wrap();
		logic [7:0] b;
		logic       r;
		bit         counts;
		while (!window_full || dec_phase != PH_FLAG) begin
			next_stream_byte(85, 1'b1, 1'b0, b, r, counts);
			send_item(b, r);
		end
		send_item(8'h00, 1'b0);
		send_item(8'h02, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
	endtask

	task automatic test_random_streams();
		logic [7:0] b;
		logic       r;
		bit         counts;
		int         taken;
		int         mix;
		taken = 0;
		mix = 40;
		while (taken < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				mix = $urandom_range(10, 80);
			next_stream_byte(mix, 1'b0, 1'b1, b, r, counts);
			send_item(b, r);
			if (counts)
				taken++;
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so
	// the command queue fills and the input side has to stall.
	task automatic test_stall_pressure();
		logic [7:0] b;
		logic       r;
		bit         counts;
		tx_steady = 1'b1;
		rx_hold = 400;
		repeat (40) begin
			next_stream_byte(80, 1'b1, 1'b0, b, r, counts);
			send_item(b, r);
		end
		tx_steady = 1'b0;
	endtask

	// Receiver: switches between always ready, coin flips and a rotating
	// comb; a hold request overrides all of them.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ch.ready <= 1'b0;
		end else begin
			if (rx_style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 2));
				rx_style_left = $urandom_range(40, 160);
			end else begin
				rx_style_left--;
			end
			case (rx_style)
				RX_OPEN: out_ch.ready <= 1'b1;
				RX_COIN: out_ch.ready <= ($urandom_range(0, 99) < 65);
				default: begin
					out_ch.ready <= rx_comb[0];
					rx_comb = {rx_comb[0], rx_comb[7:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{data: out_ch.out_byte, last: out_ch.last_of_run,
				done: out_ch.stream_done, total: out_ch.total_length};
			if (decoded_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: byte %02h last %0b done %0b total %0d",
						got.data, got.last, got.done, got.total);
			end else begin
				want = decoded_q.pop_front();
				if (got.data !== want.data || got.last !== want.last ||
						got.done !== want.done || got.total !== want.total) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch: expected byte %02h last %0b done %0b total %0d,",
							" got byte %02h last %0b done %0b total %0d"},
							want.data, want.last, want.done, want.total,
							got.data, got.last, got.done, got.total);
				end
			end
		end
	end

	// Ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("lz_window_decompressor_core regression: fail");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.restart = 1'b0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_window_wrap();
		test_random_streams();
		test_stall_pressure();
		if (tx_valid_high)
			in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && decoded_q.size() == 0)
			$display("lz_window_decompressor_core regression: pass");
		else
			$display("lz_window_decompressor_core regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
src/lzwd_pkg.sv
src/lzwd_in_if.sv
src/lzwd_out_if.sv
src/lzwd_front.sv
src/lzwd_cmd_fifo.sv
src/lzwd_back.sv
src/lz_window_decompressor_core.sv
verif/lz_window_decompressor_core_tb.sv
